// File: rtl/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

	// request operation codes
	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_CALLOC = 2'd2,
		OP_RESIZE = 2'd3
	} op_t;

	// result status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_NULL     = 3'd1;
	localparam logic [2:0] STAT_NOHEAP   = 3'd2;
	localparam logic [2:0] STAT_OVERFLOW = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;
	localparam logic [2:0] STAT_UNKNOWN  = 3'd5;

	// what the back engine has to do with a request
	typedef enum logic [1:0] {
		K_IMM    = 2'd0,
		K_ALLOC  = 2'd1,
		K_FREE   = 2'd2,
		K_RESIZE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] size;
		logic [31:0] addr;
		logic [2:0]  status;
	} cmd_t;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [31:0] HEAP_LIMIT_RESET = 32'd65536;

endpackage

// File: rtl/ffha_front.sv
// front end: request register, array size multiply and classification
`timescale 1ns / 1ps
module ffha_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       operation,
	input  logic [31:0]      request_size,
	input  logic [31:0]      element_count,
	input  logic [31:0]      payload_address,
	output logic             push,
	output ffha_pkg::cmd_t   push_cmd,
	input  logic             q_full
);

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [31:0] size_s1;
	logic [31:0] count_s1;
	logic [31:0] addr_s1;
	logic [63:0] prod;

	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || push;
	assign prod     = 64'(count_s1) * 64'(size_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= operation;
			size_s1  <= request_size;
			count_s1 <= element_count;
			addr_s1  <= payload_address;
		end
	end

	always_comb begin
		push_cmd.kind   = ffha_pkg::K_IMM;
		push_cmd.size   = size_s1;
		push_cmd.addr   = addr_s1;
		push_cmd.status = ffha_pkg::STAT_NULL;
		unique case (ffha_pkg::op_t'(op_s1))
			ffha_pkg::OP_ALLOC: begin
				if (size_s1 != 32'd0) push_cmd.kind = ffha_pkg::K_ALLOC;
			end
			ffha_pkg::OP_FREE: begin
				if (addr_s1 != 32'd0) push_cmd.kind = ffha_pkg::K_FREE;
			end
			ffha_pkg::OP_CALLOC: begin
				push_cmd.size = prod[31:0];
				if (count_s1 == 32'd0 || size_s1 == 32'd0) begin
					push_cmd.status = ffha_pkg::STAT_NULL;
				end else if (prod[63:32] != 32'd0) begin
					push_cmd.status = ffha_pkg::STAT_OVERFLOW;
				end else begin
					push_cmd.kind = ffha_pkg::K_ALLOC;
				end
			end
			ffha_pkg::OP_RESIZE: begin
				if (size_s1 == 32'd0) begin
					push_cmd.kind = ffha_pkg::K_IMM;
				end else if (addr_s1 == 32'd0) begin
					push_cmd.kind = ffha_pkg::K_ALLOC;
				end else begin
					push_cmd.kind = ffha_pkg::K_RESIZE;
				end
			end
			default: push_cmd.kind = ffha_pkg::K_IMM;
		endcase
	end

endmodule

// File: rtl/ffha_queue.sv
// short request queue between front end and back engine
`timescale 1ns / 1ps
module ffha_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ffha_pkg::cmd_t   push_cmd,
	output logic             full,
	input  logic             pop,
	output ffha_pkg::cmd_t   head,
	output logic             empty
);

	localparam int PW = $clog2(ffha_pkg::QUEUE_DEPTH);

	ffha_pkg::cmd_t         ent_q [ffha_pkg::QUEUE_DEPTH];
	logic [PW-1:0]          wr_q;
	logic [PW-1:0]          rd_q;
	logic [PW:0]            cnt_q;

	assign full  = cnt_q == (PW+1)'(ffha_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			priority if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_cmd;
	end

endmodule

// File: rtl/ffha_back.sv
// back engine: block table, first-fit and address scans, result register
`timescale 1ns / 1ps
module ffha_back #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      heap_limit,
	input  ffha_pkg::cmd_t   head,
	input  logic             q_empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      result_address,
	output logic [2:0]       status
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = IW + 1;
	localparam int SW = IW + 34;
	localparam logic [SW-1:0] HDR_S = SW'(HEADER_BYTES);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RELEASE, S_DONE} state_t;

	state_t          state_q;
	ffha_pkg::cmd_t  cmd_q;
	logic            fit_q;
	logic            grow_q;
	logic [CW-1:0]   scan_q;
	logic            chk_vld_q;
	logic [IW-1:0]   chk_idx_q;
	logic [SW-1:0]   start_q;
	logic [IW-1:0]   found_idx_q;
	logic [31:0]     found_size_q;
	logic [CW-1:0]   count_q;
	logic [31:0]     top_q;
	logic [31:0]     res_addr_q;
	logic [2:0]      res_stat_q;
	logic            out_valid_q;
	logic [31:0]     out_addr_q;
	logic [2:0]      out_stat_q;

	logic [32:0]     mem_q [MAX_BLOCKS];
	logic [32:0]     rd_data_q;
	logic            mem_we;
	logic [IW-1:0]   mem_wa;
	logic [32:0]     mem_wd;

	logic            ent_free;
	logic [31:0]     ent_size;
	logic [SW-1:0]   pay;
	logic            hit_fit;
	logic            hit_find;
	logic            regrow;
	logic            miss;
	logic [33:0]     total;
	logic            no_heap;
	logic            tbl_full;
	logic            rel_last;
	logic            out_load;

	assign ent_free = rd_data_q[32];
	assign ent_size = rd_data_q[31:0];
	assign pay      = start_q + HDR_S;
	assign hit_fit  = fit_q && chk_vld_q && ent_free && (ent_size >= cmd_q.size);
	assign hit_find = !fit_q && chk_vld_q && (pay == SW'(cmd_q.addr));
	assign regrow   = hit_find && (cmd_q.kind != ffha_pkg::K_FREE) && (ent_size < cmd_q.size);
	assign miss     = !chk_vld_q && (scan_q != '0);
	assign total    = 34'(top_q) + 34'(HEADER_BYTES) + 34'(cmd_q.size);
	assign no_heap  = total > 34'(heap_limit);
	assign tbl_full = count_q >= CW'(MAX_BLOCKS);
	assign rel_last = (CW'(found_idx_q) + 1'b1) == count_q;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign pop            = (state_q == S_IDLE) && !q_empty;
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_stat_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = chk_idx_q;
		mem_wd = {1'b0, ent_size};
		unique case (state_q)
			S_SCAN: begin
				if (hit_fit) begin
					mem_we = 1'b1;
				end else if (fit_q && miss && !no_heap && !tbl_full) begin
					mem_we = 1'b1;
					mem_wa = count_q[IW-1:0];
					mem_wd = {1'b0, cmd_q.size};
				end
			end
			S_RELEASE: begin
				mem_we = !rel_last;
				mem_wa = found_idx_q;
				mem_wd = {1'b1, found_size_q};
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rd_data_q <= mem_q[scan_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			chk_vld_q   <= 1'b0;
			scan_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_addr_q  <= res_addr_q;
				out_stat_q  <= res_stat_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						cmd_q      <= head;
						res_addr_q <= '0;
						res_stat_q <= head.status;
						scan_q     <= '0;
						chk_vld_q  <= 1'b0;
						start_q    <= '0;
						fit_q      <= head.kind == ffha_pkg::K_ALLOC;
						grow_q     <= 1'b0;
						state_q    <= (head.kind == ffha_pkg::K_IMM) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					chk_idx_q <= scan_q[IW-1:0];
					if (regrow) begin
						scan_q    <= '0;
						chk_vld_q <= 1'b0;
					end else begin
						scan_q    <= scan_q + 1'b1;
						chk_vld_q <= scan_q < count_q;
					end
					if (hit_fit) begin
						res_addr_q <= pay[31:0];
						res_stat_q <= ffha_pkg::STAT_OK;
						state_q    <= grow_q ? S_RELEASE : S_DONE;
					end else if (hit_find) begin
						found_idx_q  <= chk_idx_q;
						found_size_q <= ent_size;
						res_stat_q   <= ffha_pkg::STAT_OK;
						priority if (cmd_q.kind == ffha_pkg::K_FREE) begin
							res_addr_q <= '0;
							state_q    <= S_RELEASE;
						end else if (ent_size >= cmd_q.size) begin
							res_addr_q <= cmd_q.addr;
							state_q    <= S_DONE;
						end else begin
							// block too small: rescan for a new one
							fit_q   <= 1'b1;
							grow_q  <= 1'b1;
							start_q <= '0;
						end
					end else if (chk_vld_q) begin
						start_q <= start_q + HDR_S + SW'(ent_size);
					end else if (miss) begin
						priority if (!fit_q) begin
							res_addr_q <= '0;
							res_stat_q <= ffha_pkg::STAT_UNKNOWN;
							state_q    <= S_DONE;
						end else if (no_heap) begin
							res_addr_q <= '0;
							res_stat_q <= ffha_pkg::STAT_NOHEAP;
							state_q    <= S_DONE;
						end else if (tbl_full) begin
							res_addr_q <= '0;
							res_stat_q <= ffha_pkg::STAT_FULL;
							state_q    <= S_DONE;
						end else begin
							res_stat_q <= ffha_pkg::STAT_OK;
							res_addr_q <= top_q + 32'(HEADER_BYTES);
							top_q      <= total[31:0];
							count_q    <= count_q + 1'b1;
							state_q    <= grow_q ? S_RELEASE : S_DONE;
						end
					end
				end
				S_RELEASE: begin
					if (rel_last) begin
						top_q   <= top_q - 32'(HEADER_BYTES) - found_size_q;
						count_q <= count_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    operation, request_size, element_count,
//                                             payload_address
// out       output     out_valid / out_ready  result_address, status
// cfg       input      cfg_valid / cfg_ready  cfg_data (heap_limit)
//
// a request that walks the whole table goes through these back engine steps: pop,
// the registered table read, one step per block entry, end of walk, result load;
// a growing resize walks the table twice, and a successful free or growing resize
// also passes through the release state
// requests that need no table walk go from pop straight to result load
// arst_n clears the table count, heap top and all handshake state; block entries
// are never read before they are written, so the memory needs no clearing
// the front end and a two-entry queue keep taking requests while the back engine
// walks the table or waits on out_ready
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] request_size,
	input  logic [31:0] element_count,
	input  logic [31:0] payload_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_address,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic            q_push;
	ffha_pkg::cmd_t  q_push_cmd;
	logic            q_full;
	logic            q_pop;
	ffha_pkg::cmd_t  q_head;
	logic            q_empty;
	logic [31:0]     heap_limit_q;

	// heap limit register, writes must arrive only while idle; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= ffha_pkg::HEAP_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			heap_limit_q <= cfg_data;
		end
	end

	// front end: registers the request, multiplies array sizes, classifies
	ffha_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.request_size    (request_size),
		.element_count   (element_count),
		.payload_address (payload_address),
		.push            (q_push),
		.push_cmd        (q_push_cmd),
		.q_full          (q_full)
	);

	// decoupling queue
	ffha_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// back engine: table walks, table updates, result register
	ffha_back #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.heap_limit     (heap_limit_q),
		.head           (q_head),
		.q_empty        (q_empty),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_address (result_address),
		.status         (status)
	);

	// queue is never pushed when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("request queue overflow");

	// queue is never popped when empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("request queue underflow");

	// failed requests never grant an address
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ffha_pkg::STAT_OK) |-> result_address == 32'd0)
		else $error("address granted on failure");

	// status codes stay in range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ffha_pkg::STAT_UNKNOWN)
		else $error("status code out of range");

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the first-fit heap allocator
`timescale 1ns / 1ps
module tb_top;

	localparam int NBLK = 64;
	localparam int HDR = 16;
	// two copies of the heap table: one plans stimulus ahead, one predicts results
	localparam int PLAN = 0;
	localparam int CHECK = 1;
	localparam int PHASE_ITEMS = 256;

	typedef struct packed {
		ffha_pkg::op_t op;
		logic [31:0]   size;
		logic [31:0]   count;
		logic [31:0]   addr;
	} request_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [2:0]  status;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [31:0] request_size = '0;
	logic [31:0] element_count = '0;
	logic [31:0] payload_address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result_address;
	logic [2:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	first_fit_heap_allocator #(
		.MAX_BLOCKS  (NBLK),
		.HEADER_BYTES(HDR)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.request_size   (request_size),
		.element_count  (element_count),
		.payload_address(payload_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_address (result_address),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// heap tables, one per copy
	logic [31:0] blk_size [2][NBLK];
	bit          blk_free [2][NBLK];
	int          blk_count [2];
	logic [31:0] heap_top [2];
	logic [31:0] heap_limit [2];

	request_t pending_requests [$];
	grant_t   expected_grants [$];
	int       errors = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       hold_token = 0;
	int       hold_seen = 0;
	int       hold_left = 0;

	// payload offset of block idx in copy m
	function automatic logic [31:0] payload_at(int m, int idx);
		logic [63:0] start;
		start = 0;
		for (int i = 0; i < idx; i++)
			start += HDR + blk_size[m][i];
		return start[31:0] + HDR;
	endfunction

	function automatic int lookup_block(int m, logic [31:0] addr);
		logic [63:0] start;
		start = 0;
		for (int i = 0; i < blk_count[m]; i++) begin
			if (start + HDR == {32'd0, addr})
				return i;
			start += HDR + blk_size[m][i];
		end
		return -1;
	endfunction

	function automatic logic [2:0] grab_block(int m, logic [31:0] size, output logic [31:0] addr);
		logic [63:0] total;
		addr = '0;
		if (size == 0)
			return ffha_pkg::STAT_NULL;
		// first fit, reused whole
		for (int i = 0; i < blk_count[m]; i++) begin
			if (blk_free[m][i] && blk_size[m][i] >= size) begin
				blk_free[m][i] = 1'b0;
				addr = payload_at(m, i);
				return ffha_pkg::STAT_OK;
			end
		end
		total = {32'd0, heap_top[m]} + HDR + size;
		if (total > {32'd0, heap_limit[m]})
			return ffha_pkg::STAT_NOHEAP;
		if (blk_count[m] >= NBLK)
			return ffha_pkg::STAT_FULL;
		blk_size[m][blk_count[m]] = size;
		blk_free[m][blk_count[m]] = 1'b0;
		addr = heap_top[m] + HDR;
		blk_count[m]++;
		heap_top[m] = total[31:0];
		return ffha_pkg::STAT_OK;
	endfunction

	function automatic void drop_block(int m, int idx);
		if (idx + 1 == blk_count[m]) begin
			// last block goes away and the top comes down
			heap_top[m] = heap_top[m] - HDR - blk_size[m][idx];
			blk_count[m]--;
		end else begin
			blk_free[m][idx] = 1'b1;
		end
	endfunction

	function automatic grant_t heap_step(int m, request_t r);
		grant_t g;
		int idx;
		logic [63:0] prod;
		g.addr = '0;
		g.status = ffha_pkg::STAT_OK;
		case (r.op)
			ffha_pkg::OP_ALLOC: g.status = grab_block(m, r.size, g.addr);
			ffha_pkg::OP_FREE: begin
				if (r.addr == 0) begin
					g.status = ffha_pkg::STAT_NULL;
				end else begin
					idx = lookup_block(m, r.addr);
					if (idx < 0) g.status = ffha_pkg::STAT_UNKNOWN;
					else drop_block(m, idx);
				end
			end
			ffha_pkg::OP_CALLOC: begin
				if (r.count == 0 || r.size == 0) begin
					g.status = ffha_pkg::STAT_NULL;
				end else begin
					prod = {32'd0, r.count} * {32'd0, r.size};
					if (prod[63:32] != 0) g.status = ffha_pkg::STAT_OVERFLOW;
					else g.status = grab_block(m, prod[31:0], g.addr);
				end
			end
			default: begin
				if (r.addr == 0 || r.size == 0) begin
					g.status = grab_block(m, r.size, g.addr);
				end else begin
					idx = lookup_block(m, r.addr);
					if (idx < 0) begin
						g.status = ffha_pkg::STAT_UNKNOWN;
					end else if (blk_size[m][idx] >= r.size) begin
						g.addr = r.addr;
					end else begin
						// grow: old block freed only when the new one is granted
						g.status = grab_block(m, r.size, g.addr);
						if (g.status == ffha_pkg::STAT_OK) drop_block(m, idx);
					end
				end
			end
		endcase
		return g;
	endfunction

	task automatic queue_request(ffha_pkg::op_t op, logic [31:0] size, logic [31:0] count,
			logic [31:0] addr);
		request_t r;
		r = '{op: op, size: size, count: count, addr: addr};
		void'(heap_step(PLAN, r));
		pending_requests.push_back(r);
	endtask

	// an address that is mostly a live payload, sometimes null or bogus
	function automatic logic [31:0] pick_address();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 75 && blk_count[PLAN] > 0)
			return payload_at(PLAN, $urandom_range(0, blk_count[PLAN] - 1));
		if (sel < 85)
			return 32'd0;
		if (sel < 93 && blk_count[PLAN] > 0)
			return payload_at(PLAN, $urandom_range(0, blk_count[PLAN] - 1)) + $urandom_range(1, 8);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_size();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 80) return $urandom_range(1, 240);
		if (sel < 86) return 32'd0;
		if (sel < 92) return $urandom_range(241, 4000);
		if (sel < 96) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic queue_random();
		int sel;
		logic [31:0] cnt;
		sel = $urandom_range(0, 99);
		cnt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
		if (sel < 40)
			queue_request(ffha_pkg::OP_ALLOC, pick_size(), $urandom, $urandom);
		else if (sel < 70)
			queue_request(ffha_pkg::OP_FREE, $urandom, $urandom, pick_address());
		else if (sel < 82)
			queue_request(ffha_pkg::OP_CALLOC, ($urandom_range(0, 9) == 0) ? $urandom :
				$urandom_range(0, 40), cnt, $urandom);
		else
			queue_request(ffha_pkg::OP_RESIZE, pick_size(), $urandom, pick_address());
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0);
		// a little slack for the back engine
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		heap_limit[PLAN] = value;
		heap_limit[CHECK] = value;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic run_phase(int n);
		for (int i = 0; i < n; i++)
			queue_random();
		wait_idle();
	endtask

	// driver: offers pending requests, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_grants.push_back(heap_step(CHECK, '{op: ffha_pkg::op_t'(operation),
					size: request_size, count: element_count, addr: payload_address}));
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					request_t r;
					r = pending_requests.pop_front();
					in_valid <= 1'b1;
					operation <= r.op;
					request_size <= r.size;
					element_count <= r.count;
					payload_address <= r.addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted result, drives out_ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					$display("%0t: result with none expected: addr %h status %0d",
						$time, result_address, status);
					errors++;
				end else begin
					grant_t g;
					g = expected_grants.pop_front();
					if (result_address !== g.addr) begin
						$display("%0t: result_address expected %h actual %h",
							$time, g.addr, result_address);
						errors++;
					end
					if (status !== g.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, g.status, status);
						errors++;
					end
				end
			end
			// long hold-off so the input side backs up
			if (hold_token != hold_seen) begin
				hold_seen <= hold_token;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		logic [31:0] a;
		for (int m = 0; m < 2; m++) begin
			for (int i = 0; i < NBLK; i++) begin
				blk_size[m][i] = '0;
				blk_free[m][i] = 1'b0;
			end
			blk_count[m] = 0;
			heap_top[m] = '0;
			heap_limit[m] = ffha_pkg::HEAP_LIMIT_RESET;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: special cases at reset limit
		queue_request(ffha_pkg::OP_ALLOC, 32'd0, 32'd0, 32'd0);
		queue_request(ffha_pkg::OP_FREE, 32'd0, 32'd0, 32'd0);
		queue_request(ffha_pkg::OP_FREE, 32'd0, 32'd0, 32'hFFFF_FFFF);
		queue_request(ffha_pkg::OP_ALLOC, 32'd100, 32'd0, 32'd0);
		queue_request(ffha_pkg::OP_ALLOC, 32'd40, 32'd0, 32'd0);
		queue_request(ffha_pkg::OP_ALLOC, 32'd1, 32'd0, 32'd0);
		queue_request(ffha_pkg::OP_CALLOC, 32'd8, 32'd0, 32'd0);
		queue_request(ffha_pkg::OP_CALLOC, 32'd0, 32'd8, 32'd0);
		queue_request(ffha_pkg::OP_CALLOC, 32'h0001_0000, 32'h0001_0000, 32'd0);
		queue_request(ffha_pkg::OP_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		queue_request(ffha_pkg::OP_CALLOC, 32'd4, 32'd6, 32'd0);
		queue_request(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		a = payload_at(PLAN, 0);
		queue_request(ffha_pkg::OP_FREE, 32'd0, 32'd0, a);       // inner block marked free
		queue_request(ffha_pkg::OP_FREE, 32'd0, 32'd0, a);       // double free
		queue_request(ffha_pkg::OP_ALLOC, 32'd60, 32'd0, 32'd0);  // reuses the freed block whole
		queue_request(ffha_pkg::OP_RESIZE, 32'd20, 32'd0, 32'd0); // null address acts as allocate
		queue_request(ffha_pkg::OP_RESIZE, 32'd0, 32'd0, a);      // zero size
		queue_request(ffha_pkg::OP_RESIZE, 32'd50, 32'd0, a);     // already large enough
		queue_request(ffha_pkg::OP_RESIZE, 32'd500, 32'd0, a);    // grow, old block freed
		queue_request(ffha_pkg::OP_RESIZE, 32'd30, 32'd0, a + 1); // unknown address
		queue_request(ffha_pkg::OP_RESIZE, 32'h00FF_FFFF, 32'd0, payload_at(PLAN, 1));
		queue_request(ffha_pkg::OP_FREE, 32'd0, 32'd0, payload_at(PLAN, blk_count[PLAN] - 1));
		wait_idle();

		// no idling
		set_idling(0, 0);
		run_phase(PHASE_ITEMS);
		write_limit(32'd0);               // below the heap top: extensions fail
		run_phase(40);
		write_limit(32'd2000);
		set_idling(63, 0);
		run_phase(PHASE_ITEMS);
		write_limit(32'hFFFF_FFFF);
		set_idling(0, 63);
		run_phase(PHASE_ITEMS);
		write_limit(32'd4096 + $urandom_range(0, 20000));
		set_idling(14, 14);
		run_phase(PHASE_ITEMS);
		write_limit(ffha_pkg::HEAP_LIMIT_RESET);
		// receiver holds off while requests keep coming
		set_idling(0, 0);
		hold_token = hold_token + 1;
		run_phase(PHASE_ITEMS);

		repeat (100) @(posedge clk);
		if (errors == 0 && expected_grants.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/ffha_pkg.sv
rtl/ffha_front.sv
rtl/ffha_queue.sv
rtl/ffha_back.sv
rtl/first_fit_heap_allocator.sv
tb/tb_top.sv
